// ----- hdl/cmc_pkg.sv -----
// Shared types and constants for the comment classifier stream.
// Used by every module in the hdl folder; depends on nothing.
`default_nettype none

package cmc_pkg;

  localparam int LOOKAHEAD = 3;
  localparam int WIN_DEPTH = LOOKAHEAD + 1;
  localparam int COUNT_W = $clog2(WIN_DEPTH + 1);
  localparam int POS_W = $clog2(WIN_DEPTH);

  localparam logic [7:0] NEWLINE_CHAR = 8'd10;
  localparam logic [7:0] DASH_RESET = 8'd45;
  localparam logic [7:0] DOC_RESET = 8'd35;

  typedef enum logic [2:0] {
    KIND_CODE     = 3'd0,
    KIND_LINE     = 3'd1,
    KIND_BLOCK    = 3'd2,
    KIND_DOCLINE  = 3'd3,
    KIND_DOCBLOCK = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    MODE_CODE           = 3'd0,
    MODE_LINE           = 3'd1,
    MODE_BLOCK          = 3'd2,
    MODE_DOCLINE        = 3'd3,
    MODE_DOCBLOCK       = 3'd4,
    MODE_CLOSE_BLOCK    = 3'd5,
    MODE_CLOSE_DOCBLOCK = 3'd6
  } mode_t;

  typedef enum logic {
    REG_DASH = 1'b0,
    REG_DOC  = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [WIN_DEPTH-1:0][7:0] bytes;
    logic [COUNT_W-1:0]        avail;
    logic                      last;
  } window_t;

  typedef struct packed {
    logic [7:0] out_char;
    kind_t      kind;
    logic       is_marker;
    logic       block_newline;
    logic       out_last;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/cmc_lookahead.sv -----
// Lookahead window of the comment classifier: buffers up to four bytes and
// drains them one per cycle while popped, flushing after the final byte. Depends on cmc_pkg.
`default_nettype none

module cmc_lookahead (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [7:0]       in_char,
  input  wire logic             in_last,
  input  wire logic             pop,
  output logic                  ready,
  output logic                  win_valid,
  output cmc_pkg::window_t      win
);

  logic [cmc_pkg::WIN_DEPTH-1:0][7:0] bytes;
  logic [cmc_pkg::WIN_DEPTH-1:0][7:0] bytes_next;
  logic [cmc_pkg::COUNT_W-1:0]        count;
  logic [cmc_pkg::COUNT_W-1:0]        count_next;
  logic [cmc_pkg::POS_W-1:0]          wr_pos;
  logic                               flushing;

  assign ready = !flushing &&
                 (count != cmc_pkg::COUNT_W'(cmc_pkg::WIN_DEPTH) || pop);
  assign win_valid = flushing ? (count != '0)
                              : (count == cmc_pkg::COUNT_W'(cmc_pkg::WIN_DEPTH));

  always_comb begin
    win.bytes = bytes;
    win.avail = count;
    win.last  = flushing && (count == cmc_pkg::COUNT_W'(1));
  end

  always_comb begin
    wr_pos = cmc_pkg::POS_W'(count - cmc_pkg::COUNT_W'(pop));
    count_next = count + cmc_pkg::COUNT_W'(push) - cmc_pkg::COUNT_W'(pop);
    for (int i = 0; i < cmc_pkg::WIN_DEPTH; i++) begin
      if (pop && i < cmc_pkg::WIN_DEPTH - 1) begin
        bytes_next[i] = bytes[i+1];
      end else begin
        bytes_next[i] = bytes[i];
      end
      if (push && wr_pos == cmc_pkg::POS_W'(i)) begin
        bytes_next[i] = in_char;
      end
    end
  end

  always_ff @(posedge clk) begin
    bytes <= bytes_next;
    if (rst) begin
      count    <= '0;
      flushing <= 1'b0;
    end else begin
      count <= count_next;
      if (push && in_last) begin
        flushing <= 1'b1;
      end else if (pop && win.last) begin
        flushing <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cmc_scanner.sv -----
// Comment scanner: classifies the oldest byte of the window and keeps the
// comment mode and marker countdown. Depends on cmc_pkg.
`default_nettype none

module cmc_scanner (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pop,
  input  cmc_pkg::window_t      win,
  input  wire logic [7:0]       dash_char,
  input  wire logic [7:0]       doc_char,
  output cmc_pkg::result_t      res
);

  cmc_pkg::mode_t mode;
  cmc_pkg::mode_t mode_next;
  logic [1:0]     marker_left;
  logic [1:0]     marker_left_next;
  logic [3:0]     dash_at;
  logic [3:0]     doc_at;
  logic           is_nl;

  always_comb begin
    for (int i = 0; i < cmc_pkg::WIN_DEPTH; i++) begin
      dash_at[i] = (win.avail > cmc_pkg::COUNT_W'(i)) && (win.bytes[i] == dash_char);
      doc_at[i]  = (win.avail > cmc_pkg::COUNT_W'(i)) && (win.bytes[i] == doc_char);
    end
    is_nl = (win.bytes[0] == cmc_pkg::NEWLINE_CHAR);
  end

  always_comb begin
    mode_next         = mode;
    marker_left_next  = marker_left;
    res.out_char      = win.bytes[0];
    res.kind          = cmc_pkg::KIND_CODE;
    res.is_marker     = 1'b0;
    res.block_newline = 1'b0;
    res.out_last      = win.last;
    if (marker_left != 2'd0) begin
      res.is_marker    = 1'b1;
      marker_left_next = marker_left - 2'd1;
      unique case (mode)
        cmc_pkg::MODE_LINE:           res.kind = cmc_pkg::KIND_LINE;
        cmc_pkg::MODE_BLOCK:          res.kind = cmc_pkg::KIND_BLOCK;
        cmc_pkg::MODE_DOCLINE:        res.kind = cmc_pkg::KIND_DOCLINE;
        cmc_pkg::MODE_DOCBLOCK:       res.kind = cmc_pkg::KIND_DOCBLOCK;
        cmc_pkg::MODE_CLOSE_BLOCK:    res.kind = cmc_pkg::KIND_BLOCK;
        cmc_pkg::MODE_CLOSE_DOCBLOCK: res.kind = cmc_pkg::KIND_DOCBLOCK;
        default:                      res.kind = cmc_pkg::KIND_CODE;
      endcase
      if (marker_left == 2'd1 && (mode == cmc_pkg::MODE_CLOSE_BLOCK ||
                                  mode == cmc_pkg::MODE_CLOSE_DOCBLOCK)) begin
        mode_next = cmc_pkg::MODE_CODE;
      end
    end else begin
      unique case (mode)
        cmc_pkg::MODE_CODE: begin
          if (dash_at[0] && dash_at[1]) begin
            res.is_marker = 1'b1;
            priority if (doc_at[2]) begin
              mode_next        = cmc_pkg::MODE_DOCLINE;
              marker_left_next = 2'd2;
              res.kind         = cmc_pkg::KIND_DOCLINE;
            end else if (dash_at[2] && doc_at[3]) begin
              mode_next        = cmc_pkg::MODE_DOCBLOCK;
              marker_left_next = 2'd3;
              res.kind         = cmc_pkg::KIND_DOCBLOCK;
            end else if (dash_at[2]) begin
              mode_next        = cmc_pkg::MODE_BLOCK;
              marker_left_next = 2'd2;
              res.kind         = cmc_pkg::KIND_BLOCK;
            end else begin
              mode_next        = cmc_pkg::MODE_LINE;
              marker_left_next = 2'd1;
              res.kind         = cmc_pkg::KIND_LINE;
            end
          end
        end
        cmc_pkg::MODE_LINE, cmc_pkg::MODE_DOCLINE: begin
          if (is_nl) begin
            mode_next = cmc_pkg::MODE_CODE;
          end else begin
            res.kind = (mode == cmc_pkg::MODE_LINE) ? cmc_pkg::KIND_LINE
                                                    : cmc_pkg::KIND_DOCLINE;
          end
        end
        cmc_pkg::MODE_BLOCK: begin
          res.kind = cmc_pkg::KIND_BLOCK;
          if (dash_at[0] && dash_at[1] && dash_at[2]) begin
            res.is_marker    = 1'b1;
            mode_next        = cmc_pkg::MODE_CLOSE_BLOCK;
            marker_left_next = 2'd2;
          end else begin
            res.block_newline = is_nl;
          end
        end
        cmc_pkg::MODE_DOCBLOCK: begin
          res.kind = cmc_pkg::KIND_DOCBLOCK;
          if (dash_at[0] && dash_at[1] && dash_at[2] && doc_at[3]) begin
            res.is_marker    = 1'b1;
            mode_next        = cmc_pkg::MODE_CLOSE_DOCBLOCK;
            marker_left_next = 2'd3;
          end else begin
            res.block_newline = is_nl;
          end
        end
        default: begin
          mode_next = cmc_pkg::MODE_CODE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= cmc_pkg::MODE_CODE;
      marker_left <= 2'd0;
    end else if (pop) begin
      if (win.last) begin
        mode        <= cmc_pkg::MODE_CODE;
        marker_left <= 2'd0;
      end else begin
        mode        <= mode_next;
        marker_left <= marker_left_next;
      end
    end
  end

  // The end of a source always leaves the scanner back in code mode.
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    (pop && win.last) |=> (mode == cmc_pkg::MODE_CODE && marker_left == 2'd0))
    else $error("scanner state not cleared after final byte");

  // A closing mode always has marker bytes still to emit.
  a_close_counts: assert property (@(posedge clk) disable iff (rst)
    (mode == cmc_pkg::MODE_CLOSE_BLOCK || mode == cmc_pkg::MODE_CLOSE_DOCBLOCK)
      |-> (marker_left != 2'd0))
    else $error("closing mode without pending marker bytes");

  // A flagged newline lies in a block body and is never a marker byte.
  a_block_newline: assert property (@(posedge clk) disable iff (rst)
    res.block_newline |-> (!res.is_marker &&
      (res.kind == cmc_pkg::KIND_BLOCK || res.kind == cmc_pkg::KIND_DOCBLOCK)))
    else $error("block newline outside a block body");

endmodule

`default_nettype wire

// ----- hdl/comment_classifier_stream.sv -----
// Comment classifier stream, top level: configuration registers, the
// lookahead window, the scanner and the result register. Depends on cmc_pkg.
//
// Source bytes enter on the s_ channel, one per transaction, with s_tlast on
// the final byte of a source. Each byte leaves on the m_ channel tagged with
// its comment kind and marker and block-newline flags, m_tlast on the final
// byte. A byte is held until three further bytes have arrived, then passes
// through the scanner into the result register that drives the m_ channel.
// While the receiver does not stall, one byte is taken and one result given
// each cycle in steady state. After the final byte the window drains its
// remaining results, up to four, one per cycle while the result register is
// free, and s_tready stays low until the last one is loaded there. One
// classification per cycle sets the rate. When the receiver stalls, the result
// register holds its transaction and the window stops; s_tready falls once the window is full.
// Reset is synchronous: it empties the window, returns the scanner to code
// mode, drops m_tvalid and sets the marker bytes to '-' and '#'.
// The configuration port takes a write whenever cfg_we is high; it is meant to
// be written only while no source is in flight.
`default_nettype none

module comment_classifier_stream (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_char
  input  wire logic       s_tlast,
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_char
  output logic [4:0]      m_tuser,   // [2:0] kind, [3] is_marker, [4] block_newline
  output logic            m_tlast,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data
);

  logic [7:0]        dash_reg;
  logic [7:0]        doc_reg;
  logic              push;
  logic              pop;
  logic              win_valid;
  cmc_pkg::window_t  win;
  cmc_pkg::result_t  res;
  cmc_pkg::result_t  out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      dash_reg <= cmc_pkg::DASH_RESET;
      doc_reg  <= cmc_pkg::DOC_RESET;
    end else if (cfg_we) begin
      unique case (cmc_pkg::reg_index_t'(cfg_index))
        cmc_pkg::REG_DASH: dash_reg <= cfg_data;
        cmc_pkg::REG_DOC:  doc_reg  <= cfg_data;
        default:           dash_reg <= dash_reg;
      endcase
    end
  end

  assign push = s_tvalid && s_tready;
  assign pop  = win_valid && (!m_tvalid || m_tready);

  cmc_lookahead u_lookahead (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .pop       (pop),
    .ready     (s_tready),
    .win_valid (win_valid),
    .win       (win)
  );

  cmc_scanner u_scanner (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .win       (win),
    .dash_char (dash_reg),
    .doc_char  (doc_reg),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (pop) begin
      out_reg <= res;
    end
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = out_reg.out_char;
  assign m_tuser = {out_reg.block_newline, out_reg.is_marker, out_reg.kind};
  assign m_tlast = out_reg.out_last;

endmodule

`default_nettype wire

// ----- dv/tb_comment_classifier_stream.sv -----
// Self-checking testbench for comment_classifier_stream: directed and random
// source texts under several marker settings, with random sender gaps and
// receiver stalls. Depends on cmc_pkg and the comment_classifier_stream RTL.
`timescale 1ns / 100ps

module tb_comment_classifier_stream;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 120;
  localparam int DRAIN_CYCLES = 8;

  typedef enum {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_SPARSE} rx_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       is_final;
  } source_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic       s_tlast = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic [4:0] m_tuser;
  logic       m_tlast;
  logic       cfg_we = 1'b0;
  logic       cfg_index = cmc_pkg::REG_DASH;
  logic [7:0] cfg_data = 8'h00;

  wire s_fire = s_tvalid && s_tready;
  wire m_fire = m_tvalid && m_tready;

  comment_classifier_stream dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Marker settings as last written, and the scanner state they act on.
  logic [7:0]       dash_ch = cmc_pkg::DASH_RESET;
  logic [7:0]       doc_ch = cmc_pkg::DOC_RESET;
  logic [7:0]       held_bytes [0:cmc_pkg::LOOKAHEAD-1];
  int               held_count = 0;
  cmc_pkg::mode_t   scan_mode_q = cmc_pkg::MODE_CODE;
  int               marker_left = 0;
  logic [7:0]       scan_win [0:cmc_pkg::WIN_DEPTH-1];

  source_item_t     source_bytes [$];
  logic [7:0]       build_buf [$];
  cmc_pkg::result_t due_tags [$];

  rx_mode_t     rx_mode = RX_PATTERN;
  bit           tx_steady = 1'b0;
  int           hold_requests = 0;
  int           items_queued = 0;
  int           bytes_in = 0;
  int           sources_done = 0;
  int           results_out = 0;
  int           marker_count = 0;
  int           block_nl_count = 0;
  int           kind_count [0:7];
  int           settings_used = 1;
  int           errors = 0;

  function automatic bit win_is(input int base, input int avail, input int pos,
                                input logic [7:0] c);
    return pos < avail && scan_win[base + pos] == c;
  endfunction

  function automatic cmc_pkg::kind_t mode_kind(input cmc_pkg::mode_t m);
    if (m == cmc_pkg::MODE_CLOSE_BLOCK) return cmc_pkg::KIND_BLOCK;
    if (m == cmc_pkg::MODE_CLOSE_DOCBLOCK) return cmc_pkg::KIND_DOCBLOCK;
    return cmc_pkg::kind_t'(m);
  endfunction

  // Tags the byte at scan_win[base] given avail valid bytes from there on.
  task automatic classify_window(input int base, input int avail, input bit is_final);
    cmc_pkg::result_t r;
    cmc_pkg::kind_t   k;
    logic             mk;
    logic             nl;
    logic [7:0]       c;
    c = scan_win[base];
    mk = 1'b0;
    nl = 1'b0;
    k = cmc_pkg::KIND_CODE;
    if (marker_left > 0) begin
      k = mode_kind(scan_mode_q);
      mk = 1'b1;
      marker_left--;
      if (marker_left == 0 &&
          (scan_mode_q == cmc_pkg::MODE_CLOSE_BLOCK ||
           scan_mode_q == cmc_pkg::MODE_CLOSE_DOCBLOCK))
        scan_mode_q = cmc_pkg::MODE_CODE;
    end else begin
      case (scan_mode_q)
        cmc_pkg::MODE_CODE: begin
          if (win_is(base, avail, 0, dash_ch) && win_is(base, avail, 1, dash_ch)) begin
            mk = 1'b1;
            if (win_is(base, avail, 2, doc_ch)) begin
              scan_mode_q = cmc_pkg::MODE_DOCLINE;
              marker_left = 2;
            end else if (win_is(base, avail, 2, dash_ch)) begin
              if (win_is(base, avail, 3, doc_ch)) begin
                scan_mode_q = cmc_pkg::MODE_DOCBLOCK;
                marker_left = 3;
              end else begin
                scan_mode_q = cmc_pkg::MODE_BLOCK;
                marker_left = 2;
              end
            end else begin
              scan_mode_q = cmc_pkg::MODE_LINE;
              marker_left = 1;
            end
            k = mode_kind(scan_mode_q);
          end
        end
        cmc_pkg::MODE_LINE, cmc_pkg::MODE_DOCLINE: begin
          if (c == cmc_pkg::NEWLINE_CHAR) begin
            scan_mode_q = cmc_pkg::MODE_CODE;
          end else begin
            k = mode_kind(scan_mode_q);
          end
        end
        cmc_pkg::MODE_BLOCK: begin
          k = cmc_pkg::KIND_BLOCK;
          if (win_is(base, avail, 0, dash_ch) && win_is(base, avail, 1, dash_ch) &&
              win_is(base, avail, 2, dash_ch)) begin
            mk = 1'b1;
            scan_mode_q = cmc_pkg::MODE_CLOSE_BLOCK;
            marker_left = 2;
          end else if (c == cmc_pkg::NEWLINE_CHAR) begin
            nl = 1'b1;
          end
        end
        cmc_pkg::MODE_DOCBLOCK: begin
          k = cmc_pkg::KIND_DOCBLOCK;
          if (win_is(base, avail, 0, dash_ch) && win_is(base, avail, 1, dash_ch) &&
              win_is(base, avail, 2, dash_ch) && win_is(base, avail, 3, doc_ch)) begin
            mk = 1'b1;
            scan_mode_q = cmc_pkg::MODE_CLOSE_DOCBLOCK;
            marker_left = 3;
          end else if (c == cmc_pkg::NEWLINE_CHAR) begin
            nl = 1'b1;
          end
        end
        default: begin
          scan_mode_q = cmc_pkg::MODE_CODE;
        end
      endcase
    end
    r.out_char = c;
    r.kind = k;
    r.is_marker = mk;
    r.block_newline = nl;
    r.out_last = is_final;
    due_tags.push_back(r);
  endtask

  task automatic scan_source_byte(input logic [7:0] ch, input logic is_final);
    int n;
    for (int i = 0; i < held_count; i++) scan_win[i] = held_bytes[i];
    scan_win[held_count] = ch;
    n = held_count + 1;
    if (!is_final) begin
      if (n <= cmc_pkg::LOOKAHEAD) begin
        held_bytes[held_count] = ch;
        held_count = n;
      end else begin
        classify_window(0, cmc_pkg::WIN_DEPTH, 1'b0);
        for (int i = 0; i < cmc_pkg::LOOKAHEAD; i++) held_bytes[i] = scan_win[i + 1];
      end
    end else begin
      for (int i = 0; i < n; i++) classify_window(i, n - i, i == n - 1);
      held_count = 0;
      scan_mode_q = cmc_pkg::MODE_CODE;
      marker_left = 0;
    end
  endtask

  // Sender: bursts of random length separated by random gaps unless tx_steady is set.
  int           burst_left = 0;
  int           gap_left = 0;
  source_item_t drv_next;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_fire) begin
        scan_source_byte(s_tdata, s_tlast);
        bytes_in++;
        if (s_tlast) sources_done++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (source_bytes.size() > 0) begin
          drv_next = source_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= drv_next.ch;
          s_tlast <= drv_next.is_final;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = tx_steady ? 0 : $urandom_range(0, 5);
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern per phase, plus long hold-offs on request.
  int hold_done = 0;
  int hold_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_done != hold_requests) begin
      hold_done = hold_requests;
      hold_left = LONG_HOLD;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      rx_tick++;
      case (rx_mode)
        RX_ALWAYS:  m_tready <= 1'b1;
        RX_RANDOM:  m_tready <= $urandom_range(0, 1) == 1;
        RX_PATTERN: m_tready <= (rx_tick % 7) < 4;
        default:    m_tready <= $urandom_range(0, 3) == 0;
      endcase
    end
  end

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 10)
        $display("%0t: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
    end
  endtask

  cmc_pkg::result_t want_tag;

  always @(posedge clk) begin
    if (!rst && m_fire) begin
      results_out++;
      kind_count[m_tuser[2:0]]++;
      marker_count += m_tuser[3];
      block_nl_count += m_tuser[4];
      if (due_tags.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected result, byte 0x%0h user 0x%0h", $time, m_tdata, m_tuser);
      end else begin
        want_tag = due_tags.pop_front();
        check_field("out_char", want_tag.out_char, m_tdata);
        check_field("kind", want_tag.kind, m_tuser[2:0]);
        check_field("is_marker", want_tag.is_marker, m_tuser[3]);
        check_field("block_newline", want_tag.block_newline, m_tuser[4]);
        check_field("out_last", want_tag.out_last, m_tlast);
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || s_fire || m_fire) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles == WATCHDOG_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  function automatic logic [7:0] body_char(input bit multi_line);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(97, 122));
      4:          return 8'h20;
      5:          return multi_line ? cmc_pkg::NEWLINE_CHAR : 8'h3b;
      6:          return dash_ch;
      7:          return doc_ch;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) build_buf.push_back(s[i]);
  endtask

  task automatic put_marker(input int dashes, input bit with_doc);
    repeat (dashes) build_buf.push_back(dash_ch);
    if (with_doc) build_buf.push_back(doc_ch);
  endtask

  task automatic put_body(input bit multi_line);
    repeat ($urandom_range(0, 6)) build_buf.push_back(body_char(multi_line));
  endtask

  task automatic flush_source();
    source_item_t it;
    for (int i = 0; i < build_buf.size(); i++) begin
      it.ch = build_buf[i];
      it.is_final = i == build_buf.size() - 1;
      source_bytes.push_back(it);
    end
    items_queued += build_buf.size();
    build_buf.delete();
  endtask

  // Mostly well-formed comments with random bodies; some are left open or
  // broken, and some sources are only one to three bytes long.
  task automatic add_random_source();
    int target;
    target = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 28);
    while (build_buf.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 4)) build_buf.push_back(body_char(1'b1));
        3: begin
          put_marker(2, 1'b0);
          put_body(1'b0);
          if ($urandom_range(0, 3) != 0) build_buf.push_back(cmc_pkg::NEWLINE_CHAR);
        end
        4: begin
          put_marker(2, 1'b1);
          put_body(1'b0);
          if ($urandom_range(0, 3) != 0) build_buf.push_back(cmc_pkg::NEWLINE_CHAR);
        end
        5, 6: begin
          put_marker(3, 1'b0);
          put_body(1'b1);
          if ($urandom_range(0, 4) != 0) put_marker(3, 1'b0);
        end
        7: begin
          put_marker(3, 1'b1);
          put_body(1'b1);
          if ($urandom_range(0, 4) != 0) put_marker(3, 1'b1);
        end
        8: put_marker($urandom_range(1, 4), $urandom_range(0, 1));
        default: build_buf.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    flush_source();
  endtask

  task automatic write_reg(input cmc_pkg::reg_index_t idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == cmc_pkg::REG_DASH) dash_ch = val;
    else doc_ch = val;
  endtask

  task automatic drain();
    while (source_bytes.size() != 0 || s_tvalid || due_tags.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [7:0] dash_v, input logic [7:0] doc_v,
                           input rx_mode_t rx, input bit steady, input bit hold,
                           input int n_items);
    int first_item;
    int hold_at;
    write_reg(cmc_pkg::REG_DASH, dash_v);
    write_reg(cmc_pkg::REG_DOC, doc_v);
    settings_used++;
    rx_mode = rx;
    tx_steady = steady;
    first_item = items_queued;
    hold_at = bytes_in + 20;
    // A three-dash marker then a body byte and a newline, read under this setting.
    put_marker(3, 1'b0);
    put_text("x\n");
    flush_source();
    while (items_queued - first_item < n_items) add_random_source();
    if (hold) begin
      while (bytes_in < hold_at) @(posedge clk);
      hold_requests++;
    end
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    build_buf.push_back(8'h00);
    put_text("--\n--#");
    build_buf.push_back(8'hFF);
    flush_source();
    put_text("---\n---#");
    flush_source();
    put_text("---#---#");
    flush_source();
    put_text("-");
    flush_source();
    drain();

    run_phase(cmc_pkg::DASH_RESET, cmc_pkg::DOC_RESET, RX_ALWAYS, 1'b1, 1'b1, 65);
    run_phase(8'h00, 8'hFF, RX_RANDOM, 1'b0, 1'b0, 65);
    run_phase(8'hFF, 8'h00, RX_PATTERN, 1'b0, 1'b0, 65);
    run_phase(cmc_pkg::DASH_RESET, cmc_pkg::DASH_RESET, RX_RANDOM, 1'b0, 1'b0, 65);
    run_phase(cmc_pkg::NEWLINE_CHAR, cmc_pkg::DOC_RESET, RX_SPARSE, 1'b0, 1'b0, 60);
    run_phase(cmc_pkg::DASH_RESET, cmc_pkg::DOC_RESET, RX_RANDOM, 1'b0, 1'b1, 65);

    $display("Ran %0d sources (%0d bytes in, %0d results out) under %0d marker settings.",
             sources_done, bytes_in, results_out, settings_used);
    $display("Kinds code/line/block/docline/docblock %0d/%0d/%0d/%0d/%0d, %0d markers, %0d %s",
             kind_count[0], kind_count[1], kind_count[2], kind_count[3], kind_count[4],
             marker_count, block_nl_count, "block newlines.");
    if (errors == 0 && due_tags.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/cmc_pkg.sv
hdl/cmc_lookahead.sv
hdl/cmc_scanner.sv
hdl/comment_classifier_stream.sv
dv/tb_comment_classifier_stream.sv
